FILE: src/afm_pkg.sv
// shared constants, codes and structs of the alloc/free matcher
`timescale 1ns / 1ps

package afm_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_WIDTH  = 32;
   localparam int FIELD_W     = 32;
   localparam int NUM_W       = 32;
   localparam int PTR_W       = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
   localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // input operation codes
   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   // result kind codes
   typedef enum logic [2:0] {
      KIND_MATCHED         = 3'd0,
      KIND_UNMATCHED_FREE  = 3'd1,
      KIND_UNMATCHED_ALLOC = 3'd2,
      KIND_OVERFLOW        = 3'd3,
      KIND_EMPTY           = 3'd4
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_ARM,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   // contents of one table cell
   typedef struct packed {
      logic             valid;
      logic             pending;
      logic [PTR_W-1:0] ptr;
      logic [NUM_W-1:0] num;
   } entry_type;

   // commands broadcast to the row of cells
   typedef struct packed {
      logic              shift;
      logic              write;
      logic              kill;
      logic              unpend;
      logic              arm;
      logic              wipe;
      logic [SLOT_W-1:0] slot;
      logic [PTR_W-1:0]  wr_ptr;
      logic [NUM_W-1:0]  wr_num;
   } ring_ctrl_type;

endpackage

FILE: src/afm_cell.sv
// one table cell: holds an outstanding alloc and passes it to its neighbor on a shift
`timescale 1ns / 1ps

module afm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  afm_pkg::ring_ctrl_type ctrl,
   input  logic                  sel,
   input  afm_pkg::entry_type    next_entry,
   output afm_pkg::entry_type    entry
);

   logic                      valid_ff, valid_in;
   logic                      pending_ff, pending_in;
   logic [afm_pkg::PTR_W-1:0] ptr_ff, ptr_in;
   logic [afm_pkg::NUM_W-1:0] num_ff, num_in;

   // next cell contents
   always_comb begin
      valid_in   = valid_ff;
      pending_in = pending_ff;
      ptr_in     = ptr_ff;
      num_in     = num_ff;
      if (ctrl.shift) begin
         valid_in   = next_entry.valid;
         pending_in = next_entry.pending;
         ptr_in     = next_entry.ptr;
         num_in     = next_entry.num;
      end else begin
         if (ctrl.wipe) begin
            valid_in   = 1'b0;
            pending_in = 1'b0;
         end
         if (ctrl.arm) begin
            pending_in = valid_ff;
         end
         if (sel && ctrl.write) begin
            valid_in = 1'b1;
            ptr_in   = ctrl.wr_ptr;
            num_in   = ctrl.wr_num;
         end
         if (sel && ctrl.kill) begin
            valid_in = 1'b0;
         end
         if (sel && ctrl.unpend) begin
            pending_in = 1'b0;
         end
      end
   end

   // flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      num_ff <= num_in;
   end

   assign entry.valid   = valid_ff;
   assign entry.pending = pending_ff;
   assign entry.ptr     = ptr_ff;
   assign entry.num     = num_ff;

endmodule

FILE: src/afm_ring.sv
// row of table cells closed into a ring; the head cell faces the comparator
`timescale 1ns / 1ps

module afm_ring (
   input  logic                               clock,
   input  logic                               reset,
   input  afm_pkg::ring_ctrl_type             ctrl,
   output afm_pkg::entry_type                 head,
   output logic [afm_pkg::TABLE_DEPTH-1:0]    valid_vec,
   output logic [afm_pkg::TABLE_DEPTH-1:0]    pending_vec
);

   afm_pkg::entry_type entries [afm_pkg::TABLE_DEPTH];

   // each cell takes its upper neighbor on a shift, the top one wraps to the head
   for (genvar i = 0; i < afm_pkg::TABLE_DEPTH; i++) begin : g_cell
      logic sel;
      assign sel = (ctrl.slot == afm_pkg::SLOT_W'(i));

      afm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sel        (sel),
         .next_entry (entries[(i + 1) % afm_pkg::TABLE_DEPTH]),
         .entry      (entries[i])
      );

      assign valid_vec[i]   = entries[i].valid;
      assign pending_vec[i] = entries[i].pending;
   end

   assign head = entries[0];

endmodule

FILE: src/alloc_free_matcher.sv
// alloc/free matcher top level: controller, head comparator and result register
// an alloc is written into the lowest free slot, or gives an overflow result on a full table;
// a free gives its result after one full rotation of the cell ring past the head comparator
// a finish gives one result per outstanding alloc, one rotation each, or one empty result
// throughput: one item at a time; the next item is taken while a result waits
// reset: synchronous, clears valid and pending bits, counters and the result valid flag
`timescale 1ns / 1ps

module alloc_free_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] report_index, [63:32] pointer_value,
                                    // [95:64] unmatched_total
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast
);

   localparam int D  = afm_pkg::TABLE_DEPTH;
   localparam int SW = afm_pkg::SLOT_W;
   localparam int PW = afm_pkg::PTR_W;
   localparam int NW = afm_pkg::NUM_W;
   localparam int FW = afm_pkg::FIELD_W;

   afm_pkg::state_type     state_ff, state_in;
   afm_pkg::op_type        op_ff, op_in;
   logic [PW-1:0]          addr_ff, addr_in;
   logic [NW-1:0]          num_ff, num_in;
   logic [NW-1:0]          counter_ff, counter_in;
   logic [NW-1:0]          unmatched_ff, unmatched_in;
   logic [SW-1:0]          step_ff, step_in;
   logic                   found_ff, found_in;
   logic [NW-1:0]          best_age_ff, best_age_in;
   logic [SW-1:0]          best_slot_ff, best_slot_in;
   logic [NW-1:0]          best_num_ff, best_num_in;
   logic [PW-1:0]          best_ptr_ff, best_ptr_in;
   afm_pkg::kind_type      res_kind_ff, res_kind_in;
   logic [NW-1:0]          res_index_ff, res_index_in;
   logic [PW-1:0]          res_ptr_ff, res_ptr_in;
   logic                   res_last_ff, res_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   afm_pkg::kind_type      rsp_kind_ff, rsp_kind_in;
   logic [FW-1:0]          rsp_index_ff, rsp_index_in;
   logic [FW-1:0]          rsp_ptr_ff, rsp_ptr_in;
   logic [FW-1:0]          rsp_total_ff, rsp_total_in;
   logic                   rsp_last_ff, rsp_last_in;

   afm_pkg::ring_ctrl_type ring_ctrl;
   afm_pkg::entry_type     head;
   logic [D-1:0]           valid_vec;
   logic [D-1:0]           pending_vec;

   logic                   any_free;
   logic [SW-1:0]          first_free;
   logic [NW-1:0]          scan_ref;
   logic [NW-1:0]          age;
   logic                   eligible;
   logic                   better;
   logic [NW-1:0]          unmatched_inc;
   logic                   out_free;
   logic [D-1:0]           best_mask;
   logic                   others_left;

   afm_ring u_ring (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ring_ctrl),
      .head        (head),
      .valid_vec   (valid_vec),
      .pending_vec (pending_vec)
   );

   // lowest free slot
   always_comb begin
      first_free = '0;
      for (int i = D - 1; i >= 0; i--) begin
         if (!valid_vec[i]) begin
            first_free = SW'(i);
         end
      end
   end
   assign any_free = ~&valid_vec;

   // head comparator: newest match for a free, oldest pending for a drain
   assign scan_ref = (op_ff == afm_pkg::OP_FREE) ? num_ff : counter_ff;
   assign age      = scan_ref - head.num;
   assign eligible = (op_ff == afm_pkg::OP_FREE) ? (head.valid && (head.ptr == addr_ff))
                                                 : head.pending;
   assign better   = !found_ff || ((op_ff == afm_pkg::OP_FREE) ? (age < best_age_ff)
                                                               : (age > best_age_ff));

   // saturating unmatched count
   assign unmatched_inc = (unmatched_ff == {NW{1'b1}}) ? unmatched_ff
                                                       : unmatched_ff + NW'(1);

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign best_mask   = {{(D - 1){1'b0}}, 1'b1} << best_slot_ff;
   assign others_left = |(pending_vec & ~best_mask);

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      num_in       = num_ff;
      counter_in   = counter_ff;
      unmatched_in = unmatched_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      best_age_in  = best_age_ff;
      best_slot_in = best_slot_ff;
      best_num_in  = best_num_ff;
      best_ptr_in  = best_ptr_ff;
      res_kind_in  = res_kind_ff;
      res_index_in = res_index_ff;
      res_ptr_in   = res_ptr_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_ptr_in   = rsp_ptr_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      ring_ctrl    = '0;
      req_tready   = 1'b0;

      unique case (state_ff)
         afm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               addr_in = req_tdata[PW-1:0];
               unique case (req_tuser)
                  afm_pkg::OP_ALLOC: begin
                     op_in      = afm_pkg::OP_ALLOC;
                     num_in     = counter_ff;
                     counter_in = counter_ff + NW'(1);
                     state_in   = afm_pkg::ST_ALLOC;
                  end
                  afm_pkg::OP_FREE: begin
                     op_in      = afm_pkg::OP_FREE;
                     num_in     = counter_ff;
                     counter_in = counter_ff + NW'(1);
                     found_in   = 1'b0;
                     step_in    = '0;
                     state_in   = afm_pkg::ST_SCAN;
                  end
                  afm_pkg::OP_FINISH: begin
                     op_in    = afm_pkg::OP_FINISH;
                     state_in = afm_pkg::ST_ARM;
                  end
                  default: begin
                     state_in = afm_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         afm_pkg::ST_ALLOC: begin
            if (any_free) begin
               ring_ctrl.write  = 1'b1;
               ring_ctrl.slot   = first_free;
               ring_ctrl.wr_ptr = addr_ff;
               ring_ctrl.wr_num = num_ff;
               state_in         = afm_pkg::ST_IDLE;
            end else begin
               unmatched_in = unmatched_inc;
               res_kind_in  = afm_pkg::KIND_OVERFLOW;
               res_index_in = num_ff;
               res_ptr_in   = addr_ff;
               res_last_in  = 1'b1;
               state_in     = afm_pkg::ST_EMIT;
            end
         end

         afm_pkg::ST_ARM: begin
            ring_ctrl.arm = 1'b1;
            if (|valid_vec) begin
               found_in = 1'b0;
               step_in  = '0;
               state_in = afm_pkg::ST_SCAN;
            end else begin
               res_kind_in  = afm_pkg::KIND_EMPTY;
               res_index_in = '0;
               res_ptr_in   = '0;
               res_last_in  = 1'b1;
               state_in     = afm_pkg::ST_EMIT;
            end
         end

         // one full rotation of the ring, one cell past the comparator per cycle
         afm_pkg::ST_SCAN: begin
            ring_ctrl.shift = 1'b1;
            if (eligible && better) begin
               found_in     = 1'b1;
               best_age_in  = age;
               best_slot_in = step_ff;
               best_num_in  = head.num;
               best_ptr_in  = head.ptr;
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(D - 1)) begin
               step_in  = '0;
               state_in = afm_pkg::ST_DECIDE;
            end
         end

         afm_pkg::ST_DECIDE: begin
            ring_ctrl.slot = best_slot_ff;
            if (op_ff == afm_pkg::OP_FREE) begin
               res_index_in = num_ff;
               res_ptr_in   = addr_ff;
               res_last_in  = 1'b1;
               if (found_ff) begin
                  ring_ctrl.kill = 1'b1;
                  res_kind_in    = afm_pkg::KIND_MATCHED;
               end else begin
                  unmatched_in = unmatched_inc;
                  res_kind_in  = afm_pkg::KIND_UNMATCHED_FREE;
               end
            end else begin
               ring_ctrl.unpend = 1'b1;
               unmatched_in     = unmatched_inc;
               res_kind_in      = afm_pkg::KIND_UNMATCHED_ALLOC;
               res_index_in     = best_num_ff;
               res_ptr_in       = best_ptr_ff;
               res_last_in      = !others_left;
            end
            state_in = afm_pkg::ST_EMIT;
         end

         afm_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_index_in = FW'(res_index_ff);
               rsp_ptr_in   = FW'(res_ptr_ff);
               rsp_total_in = FW'(unmatched_ff);
               rsp_last_in  = res_last_ff;
               if (op_ff == afm_pkg::OP_FINISH) begin
                  if (res_last_ff) begin
                     ring_ctrl.wipe = 1'b1;
                     counter_in     = '0;
                     unmatched_in   = '0;
                     state_in       = afm_pkg::ST_IDLE;
                  end else begin
                     found_in = 1'b0;
                     step_in  = '0;
                     state_in = afm_pkg::ST_SCAN;
                  end
               end else begin
                  state_in = afm_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = afm_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afm_pkg::ST_IDLE;
         counter_ff   <= '0;
         unmatched_ff <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         unmatched_ff <= unmatched_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      num_ff       <= num_in;
      best_age_ff  <= best_age_in;
      best_slot_ff <= best_slot_in;
      best_num_ff  <= best_num_in;
      best_ptr_ff  <= best_ptr_in;
      res_kind_ff  <= res_kind_in;
      res_index_ff <= res_index_in;
      res_ptr_ff   <= res_ptr_in;
      res_last_ff  <= res_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ptr_ff   <= rsp_ptr_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_ptr_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the ring is back at its home position whenever a decision is taken
   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == afm_pkg::ST_DECIDE) |-> (step_ff == '0))
      else $error("ring not at home position at decision");

   // a matched free removes an entry that is really outstanding
   a_kill_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == afm_pkg::ST_DECIDE && op_ff == afm_pkg::OP_FREE && found_ff)
      |-> valid_vec[best_slot_ff])
      else $error("matched free points at an empty slot");

   // a drain rotation always finds a pending entry
   a_drain_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == afm_pkg::ST_DECIDE && op_ff == afm_pkg::OP_FINISH) |-> found_ff)
      else $error("drain rotation found nothing pending");

   // the final drain transaction leaves an empty table
   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == afm_pkg::ST_EMIT && out_free && op_ff == afm_pkg::OP_FINISH && res_last_ff)
      |=> (valid_vec == '0 && counter_ff == '0))
      else $error("table not cleared after drain");

   // an alloc into a full table produces an overflow result
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == afm_pkg::ST_ALLOC && !any_free)
      |=> (state_ff == afm_pkg::ST_EMIT && res_kind_ff == afm_pkg::KIND_OVERFLOW))
      else $error("full table alloc did not overflow");
`endif

endmodule

FILE: tb/tb_alloc_free_matcher.sv
// self-checking testbench for the alloc/free matcher: stream stimulus, pairing predictor, checks
`timescale 1ns / 1ps

module tb_alloc_free_matcher;
   import afm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 430;
   localparam int POOL_SIZE = 4;

   // one expected result transaction
   typedef struct {
      kind_type    kind;
      logic [31:0] index;
      logic [31:0] ptr;
      logic [31:0] total;
      logic        last;
   } match_result_type;

   // tracks outstanding allocs and the results each report should cause
   class match_ledger;
      logic [31:0]      slot_ptr [TABLE_DEPTH];
      logic [31:0]      slot_num [TABLE_DEPTH];
      bit               slot_used [TABLE_DEPTH];
      logic [31:0]      report_count;
      logic [31:0]      unmatched;
      match_result_type awaited [$];
      int               errors;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         report_count = '0;
         unmatched = '0;
         errors = 0;
      endfunction

      function void bump_unmatched();
         if (unmatched != 32'hFFFF_FFFF) unmatched++;
      endfunction

      function void push_result(kind_type kind, logic [31:0] index, logic [31:0] ptr,
                                logic last);
         match_result_type r;
         r.kind = kind;
         r.index = index;
         r.ptr = ptr;
         r.total = unmatched;
         r.last = last;
         awaited.push_back(r);
      endfunction

      // apply one accepted request to the table
      function void note_report(logic [1:0] op, logic [31:0] addr);
         int          hit;
         int          left;
         logic [31:0] num;
         logic [31:0] age;
         logic [31:0] best_age;
         bit          waiting [TABLE_DEPTH];
         case (op)
            OP_ALLOC: begin
               num = report_count;
               report_count++;
               hit = -1;
               for (int i = 0; i < TABLE_DEPTH; i++)
                  if (!slot_used[i] && hit < 0) hit = i;
               if (hit >= 0) begin
                  slot_used[hit] = 1'b1;
                  slot_ptr[hit] = addr;
                  slot_num[hit] = num;
               end else begin
                  bump_unmatched();
                  push_result(KIND_OVERFLOW, num, addr, 1'b1);
               end
            end
            OP_FREE: begin
               num = report_count;
               report_count++;
               hit = -1;
               best_age = '0;
               // youngest outstanding alloc with this address, lowest slot on a tie
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (slot_used[i] && slot_ptr[i] == addr) begin
                     age = num - slot_num[i];
                     if (hit < 0 || age < best_age) begin
                        hit = i;
                        best_age = age;
                     end
                  end
               end
               if (hit >= 0) begin
                  slot_used[hit] = 1'b0;
                  push_result(KIND_MATCHED, num, addr, 1'b1);
               end else begin
                  bump_unmatched();
                  push_result(KIND_UNMATCHED_FREE, num, addr, 1'b1);
               end
            end
            OP_FINISH: begin
               left = 0;
               foreach (waiting[i]) begin
                  waiting[i] = slot_used[i];
                  if (waiting[i]) left++;
               end
               if (left == 0) push_result(KIND_EMPTY, '0, '0, 1'b1);
               // drain oldest first
               while (left > 0) begin
                  hit = -1;
                  best_age = '0;
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (waiting[i]) begin
                        age = report_count - slot_num[i];
                        if (hit < 0 || age > best_age) begin
                           hit = i;
                           best_age = age;
                        end
                     end
                  end
                  waiting[hit] = 1'b0;
                  left--;
                  bump_unmatched();
                  push_result(KIND_UNMATCHED_ALLOC, slot_num[hit], slot_ptr[hit], left == 0);
               end
               foreach (slot_used[i]) slot_used[i] = 1'b0;
               report_count = '0;
               unmatched = '0;
            end
            default: ;
         endcase
      endfunction

      // compare one accepted result against the oldest expectation
      function void check_result(logic [2:0] kind, logic [31:0] index, logic [31:0] ptr,
                                 logic [31:0] total, logic last);
         match_result_type e;
         if (awaited.size() == 0) begin
            $error("result with none expected: kind %0d index %0d", kind, index);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (kind !== e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, kind);
            errors++;
         end
         if (index !== e.index) begin
            $error("report_index: expected %0d, actual %0d", e.index, index);
            errors++;
         end
         if (ptr !== e.ptr) begin
            $error("pointer_value: expected %08h, actual %08h", e.ptr, ptr);
            errors++;
         end
         if (total !== e.total) begin
            $error("unmatched_total: expected %0d, actual %0d", e.total, total);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] address
   logic [1:0]  req_tuser = '0;    // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // [31:0] report_index, [63:32] pointer_value,
                                   // [95:64] unmatched_total
   logic [2:0]  rsp_tuser;         // [2:0] kind
   logic        rsp_tlast;

   match_ledger ledger = new();
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_req = 0;
   int          items_sent = 0;

   alloc_free_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // present one request and wait for its transaction
   task automatic offer(input logic [1:0] op, input logic [31:0] addr);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= addr;
      do @(posedge clock); while (!req_tready);
      ledger.note_report(op, addr);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // result side: check transactions, random stalls and long hold-offs
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            ledger.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32],
                                rsp_tdata[95:64], rsp_tlast);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // stimulus and end of run
   initial begin : req_side
      logic [31:0] pool [POOL_SIZE];
      logic [31:0] live [$];
      logic [31:0] addr;
      int          choice;
      int          n;
      int          j;
      int          phase;
      bit          held;
      bit          filled1;
      bit          filled2;

      held = 1'b0;
      filled1 = 1'b0;
      filled2 = 1'b0;
      foreach (pool[i]) pool[i] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty drain, extremes, recency, ignored operation, ordered drain
      offer(OP_FINISH, 32'hFFFF_FFFF);
      offer(OP_ALLOC, 32'h0000_0000);
      offer(OP_ALLOC, 32'hFFFF_FFFF);
      offer(OP_ALLOC, 32'hDEAD_BEEF);
      offer(OP_ALLOC, 32'hDEAD_BEEF);
      offer(OP_FREE, 32'hDEAD_BEEF);
      offer(OP_FREE, 32'hFFFF_FFFF);
      offer(OP_FREE, 32'h1234_5678);
      offer(OP_UNUSED, 32'hFFFF_FFFF);
      offer(OP_UNUSED, 32'h0000_0000);
      offer(OP_FREE, 32'hDEAD_BEEF);
      offer(OP_FREE, 32'hDEAD_BEEF);
      offer(OP_FINISH, 32'h0000_0000);
      offer(OP_FINISH, 32'h0000_0000);
      offer(OP_ALLOC, 32'h5555_5555);
      offer(OP_ALLOC, 32'hAAAA_AAAA);
      offer(OP_ALLOC, 32'h5555_5555);
      offer(OP_FREE, 32'hAAAA_AAAA);
      offer(OP_FREE, 32'h0000_0000);
      offer(OP_FINISH, 32'hAAAA_AAAA);

      // random bursts across the idling phases
      while (items_sent < ITEM_TARGET) begin
         phase = items_sent * 4 / ITEM_TARGET;
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         // long receiver hold-off while requests keep coming
         if (!held) begin
            held = 1'b1;
            hold_req = 500;
         end
         if ($urandom_range(9) < 3) pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
         choice = $urandom_range(99);
         if ((phase == 1 && !filled1) || (phase == 2 && !filled2)) begin
            // fill the table past its depth, then drain it
            if (phase == 1) filled1 = 1'b1;
            else filled2 = 1'b1;
            repeat (TABLE_DEPTH + $urandom_range(2, 6)) offer(OP_ALLOC, $urandom);
            offer(OP_FREE, $urandom);
            offer(OP_FINISH, $urandom);
         end else if (choice < 70) begin
            // allocs from a small address pool, then frees in shuffled order
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
               addr = pool[$urandom_range(POOL_SIZE - 1)];
               live.push_back(addr);
               offer(OP_ALLOC, addr);
            end
            while (live.size() > 0) begin
               j = $urandom_range(live.size() - 1);
               if ($urandom_range(9) < 8) offer(OP_FREE, live[j]);
               live.delete(j);
            end
         end else if (choice < 84) begin
            // stray free, pool address or random
            addr = ($urandom_range(1) != 0) ? pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
            offer(OP_FREE, addr);
         end else if (choice < 92) begin
            offer(OP_UNUSED, $urandom);
         end else begin
            offer(OP_FINISH, $urandom);
         end
      end
      req_tvalid <= 1'b0;

      // let every expected result arrive, then watch for strays
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (3 * TABLE_DEPTH + 10) @(posedge clock);
      if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
         $display("alloc_free_matcher regression: pass");
      end else begin
         $display("alloc_free_matcher regression: fail");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #200_000_000;
      $display("alloc_free_matcher regression: fail");
      $finish;
   end

endmodule
